>>> src/icmp_eu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package icmp_eu_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int COPY_EXTRA       = 64;
    localparam int PAD_BYTES        = 4;
    localparam int HDR_BYTES        = 4 + PAD_BYTES;
    localparam int HDR_CNT_W        = $clog2(HDR_BYTES + 1);
    localparam int OFF_RAW_W        = $clog2(MAX_PACKET_BYTES + 1);
    localparam int OFF_W            = (OFF_RAW_W > 8) ? OFF_RAW_W : 8;

    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] ICMP_UNREACH      = 8'd3;
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] CODE_PROTO_UNREACH = 8'd2;
    localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;

    typedef enum logic [2:0] {
        ST_ECHO_REPLY    = 3'd0,
        ST_UNREACH_BUILT = 3'd1,
        ST_BAD_CSUM      = 3'd2,
        ST_PROTO_UNREACH = 3'd3,
        ST_PORT_UNREACH  = 3'd4,
        ST_UNHANDLED     = 3'd5
    } t_status;

    typedef struct packed {
        logic        hdr;
        logic [7:0]  code;
        logic        data_en;
        logic [7:0]  data;
        logic        verd;
        logic [15:0] csum;
        t_status     status;
    } t_desc;

    function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] w);
        logic [17:0] t;
        t = {1'b0, s} + {2'b00, w};
        return {1'b0, t[15:0]} + {15'd0, t[17:16]};
    endfunction

    function automatic logic [15:0] oc_fold(input logic [16:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {16'd0, s[16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

`default_nettype wire

>>> src/icmp_eu_core.sv
`timescale 1ns / 1ps
`default_nettype none

module icmp_eu_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_cmd,
    input  wire logic [7:0]         i_unreach_code,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last,
    output icmp_eu_pkg::t_desc      o_desc
);
    import icmp_eu_pkg::*;

    logic [OFF_W-1:0] r_off, n_off;
    logic             r_mode, n_mode;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_limit, n_limit;
    logic [16:0]      r_chk, n_chk;
    logic [16:0]      r_rep, n_rep;
    logic [7:0]       r_pend, n_pend;

    logic             first;
    logic [16:0]      chk_e, rep_e;
    logic [7:0]       pend_e, type_rep;
    logic [15:0]      w, rw, pw, prw;
    logic [OFF_W-1:0] limit_x, counted;
    t_desc            d;

    always_comb begin
        first    = (r_off == '0);
        n_mode   = first ? i_cmd : r_mode;
        n_type   = first ? i_data_byte : r_type;
        n_code   = first ? (i_cmd ? i_unreach_code : 8'd0) : r_code;
        n_limit  = first ? (i_cmd ? ({2'b00, i_data_byte[3:0], 2'b00} + 8'(COPY_EXTRA)) : 8'd0)
                         : r_limit;
        chk_e    = first ? 17'd0 : r_chk;
        rep_e    = first ? (i_cmd ? {1'b0, ICMP_UNREACH, i_unreach_code} : 17'd0) : r_rep;
        pend_e   = first ? 8'd0 : r_pend;
        type_rep = (n_type == ICMP_ECHO_REQUEST) ? ICMP_ECHO_REPLY : n_type;
        limit_x  = {{(OFF_W-8){1'b0}}, n_limit};

        n_off  = r_off;
        n_chk  = chk_e;
        n_rep  = rep_e;
        n_pend = pend_e;
        w      = {pend_e, i_data_byte};
        rw     = w;

        d         = '0;
        d.hdr     = first && i_cmd;
        d.code    = i_unreach_code;
        d.data    = i_data_byte;
        d.verd    = i_last;
        d.status  = ST_ECHO_REPLY;

        if (r_off < OFF_W'(MAX_PACKET_BYTES)) begin
            n_off = r_off + 1'b1;
            if (!n_mode) begin
                d.data_en = 1'b1;
                if (r_off == OFF_W'(1)) begin
                    n_code = i_data_byte;
                end
                if ((first && i_data_byte == ICMP_ECHO_REQUEST) || r_off == OFF_W'(2)
                        || r_off == OFF_W'(3)) begin
                    d.data = 8'd0;
                end
                if (!r_off[0]) begin
                    n_pend = i_data_byte;
                end else begin
                    n_chk = oc_add(chk_e, w);
                    if (r_off == OFF_W'(1)) begin
                        rw = {type_rep, i_data_byte};
                    end else if (r_off == OFF_W'(3)) begin
                        rw = 16'd0;
                    end
                    n_rep = oc_add(rep_e, rw);
                end
            end else if (r_off < limit_x) begin
                d.data_en = 1'b1;
                if (!r_off[0]) begin
                    n_pend = i_data_byte;
                end else begin
                    n_rep = oc_add(rep_e, w);
                end
            end
        end

        counted = (n_mode && n_off > limit_x) ? limit_x : n_off;
        pw      = {n_pend, 8'd0};
        prw     = pw;
        if (i_last && counted[0]) begin
            if (!n_mode) begin
                n_chk = oc_add(n_chk, pw);
                if (counted == OFF_W'(1)) begin
                    prw = {type_rep, 8'd0};
                end else if (counted == OFF_W'(3)) begin
                    prw = 16'd0;
                end
            end
            n_rep = oc_add(n_rep, prw);
        end

        priority if (n_mode) begin
            d.status = ST_UNREACH_BUILT;
            d.csum   = ~oc_fold(n_rep);
        end else if (oc_fold(n_chk) != 16'hFFFF) begin
            d.status = ST_BAD_CSUM;
        end else if (n_type == ICMP_ECHO_REQUEST) begin
            d.status = ST_ECHO_REPLY;
            d.csum   = ~oc_fold(n_rep);
        end else if (n_type == ICMP_UNREACH) begin
            priority if (n_code == CODE_PROTO_UNREACH) begin
                d.status = ST_PROTO_UNREACH;
            end else if (n_code == CODE_PORT_UNREACH) begin
                d.status = ST_PORT_UNREACH;
            end else begin
                d.status = ST_UNHANDLED;
            end
        end else begin
            d.status = ST_UNHANDLED;
        end

        if (i_last) begin
            n_off = '0;
        end
    end

    assign o_desc = d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_mode  <= 1'b0;
            r_type  <= 8'd0;
            r_code  <= 8'd0;
            r_limit <= 8'd0;
            r_chk   <= 17'd0;
            r_rep   <= 17'd0;
            r_pend  <= 8'd0;
        end else if (i_accept) begin
            r_off   <= n_off;
            r_mode  <= n_mode;
            r_type  <= n_type;
            r_code  <= n_code;
            r_limit <= n_limit;
            r_chk   <= n_chk;
            r_rep   <= n_rep;
            r_pend  <= n_pend;
        end
    end

endmodule

`default_nettype wire

>>> src/icmp_eu_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module icmp_eu_emit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire icmp_eu_pkg::t_desc i_desc,
    input  wire logic               i_stall,
    output logic                    o_ready,
    output logic                    o_valid,
    output logic                    o_kind,
    output logic [7:0]              o_out_byte,
    output logic [15:0]             o_checksum,
    output logic [2:0]              o_status,
    output logic                    o_run_end
);
    import icmp_eu_pkg::*;

    logic                 r_busy;
    logic [HDR_CNT_W-1:0] r_hdr_left;
    logic                 r_data_pend;
    logic                 r_verd_pend;
    t_desc                r_desc;

    logic pop, is_last, load;

    always_comb begin
        o_kind     = 1'b0;
        o_out_byte = 8'd0;
        o_checksum = 16'd0;
        o_status   = 3'd0;
        is_last    = 1'b1;
        if (r_hdr_left != '0) begin
            is_last = (r_hdr_left == HDR_CNT_W'(1)) && !r_data_pend && !r_verd_pend;
            if (r_hdr_left == HDR_CNT_W'(HDR_BYTES)) begin
                o_out_byte = ICMP_UNREACH;
            end else if (r_hdr_left == HDR_CNT_W'(HDR_BYTES - 1)) begin
                o_out_byte = r_desc.code;
            end
        end else if (r_data_pend) begin
            is_last    = !r_verd_pend;
            o_out_byte = r_desc.data;
        end else begin
            o_kind     = 1'b1;
            o_checksum = r_desc.csum;
            o_status   = r_desc.status;
        end
    end

    assign o_valid   = r_busy;
    assign o_run_end = is_last;
    assign pop       = r_busy && !i_stall;
    assign o_ready   = !r_busy || (pop && is_last);
    assign load      = i_accept && (i_desc.hdr || i_desc.data_en || i_desc.verd);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_hdr_left  <= '0;
            r_data_pend <= 1'b0;
            r_verd_pend <= 1'b0;
        end else if (load) begin
            r_busy      <= 1'b1;
            r_hdr_left  <= i_desc.hdr ? HDR_CNT_W'(HDR_BYTES) : '0;
            r_data_pend <= i_desc.data_en;
            r_verd_pend <= i_desc.verd;
        end else if (pop) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end
            if (r_hdr_left != '0) begin
                r_hdr_left <= r_hdr_left - 1'b1;
            end else if (r_data_pend) begin
                r_data_pend <= 1'b0;
            end else begin
                r_verd_pend <= 1'b0;
            end
        end
    end

    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_left <= HDR_CNT_W'(HDR_BYTES))
        else $error("header count out of range");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_run_end)
        else $error("verdict word is not the final word");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_run_end && !load |=> !o_valid)
        else $error("output stays valid after the final word");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_checksum == 16'd0 && o_status == 3'd0)
        else $error("data word carries verdict fields");

    a_busy_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !o_kind |-> r_hdr_left != '0 || r_data_pend)
        else $error("busy with no pending word");

endmodule

`default_nettype wire

>>> src/icmp_echo_unreach_engine_top.sv
// The first word caused by an accepted byte is offered in the cycle after acceptance.
// One input byte per cycle while each byte gives a single word and i_stall is low; the first
// byte of a build-mode packet gives up to ten words, and input stalls meanwhile. The output
// register drains one word per cycle when unstalled; a byte's last word frees it for the next.
// Reset (i_rst_n low, synchronous) clears packet state and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_unreach_engine_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_unreach_code,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic [7:0]       o_out_byte,
    output logic [15:0]      o_checksum,
    output logic [2:0]       o_status,
    output logic             o_run_end
);
    import icmp_eu_pkg::*;

    t_desc desc;
    logic  ready;
    logic  accept;

    assign o_stall = !ready;
    assign accept  = i_valid && ready;

    icmp_eu_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_cmd          (i_cmd),
        .i_unreach_code (i_unreach_code),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .o_desc         (desc)
    );

    icmp_eu_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_desc     (desc),
        .i_stall    (i_stall),
        .o_ready    (ready),
        .o_valid    (o_valid),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte),
        .o_checksum (o_checksum),
        .o_status   (o_status),
        .o_run_end  (o_run_end)
    );

endmodule

`default_nettype wire
